/* sv/pfs_pkg.sv */
`timescale 1ns / 1ps
// Package for the protobuf clock field scanner: status codes, wire types,
// register indexes and the structs passed between the scanner's modules.
// No dependencies.
package pfs_pkg;

  localparam int unsigned FIELD_W = 29;
  localparam int unsigned CLOCK_W = 63;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VARINT  = 3'd1,
    ST_FIELD_ZERO  = 3'd2,
    ST_BAD_WIRE    = 3'd3,
    ST_SKIP_OVERRUN = 3'd4,
    ST_MISSING     = 3'd5,
    ST_TOO_LARGE   = 3'd6
  } status_t;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic CFG_CLOCK_FIELD = 1'b0;
  localparam logic CFG_RAW_FIELD   = 1'b1;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       last_byte;
  } pfs_item_t;

  typedef struct packed {
    status_t              status;
    logic [CLOCK_W-1:0]   clock_ms;
    logic                 raw_clock;
  } pfs_result_t;

endpackage

/* sv/pfs_byte_parser.sv */
`timescale 1ns / 1ps
// Per-byte protobuf parser: varint assembly, key decode, skip counting and
// the end-of-message verdict. Depends on pfs_pkg.
module pfs_byte_parser
  import pfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  pfs_item_t           item,
  input  logic [FIELD_W-1:0]  clock_field,
  input  logic [FIELD_W-1:0]  raw_field,
  output logic                res_valid,
  output pfs_result_t         res
);

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_LEN   = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [1:0]  match_r, match_nxt;
  logic [63:0] skip_r, skip_nxt;
  logic [63:0] clock_r, clock_nxt;
  logic        clock_seen_r, clock_seen_nxt;
  logic        raw_r, raw_nxt;
  status_t     err_r, err_nxt;

  logic [6:0]  shamt;
  logic [63:0] acc_sum;
  status_t     verdict;

  assign shamt   = 7'(cnt_r) * 7'd7;
  assign acc_sum = acc_r | ({57'd0, item.message_byte[6:0]} << shamt);

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    match_nxt      = match_r;
    skip_nxt       = skip_r;
    clock_nxt      = clock_r;
    clock_seen_nxt = clock_seen_r;
    raw_nxt        = raw_r;
    err_nxt        = err_r;
    verdict        = ST_OK;
    res_valid      = go && item.last_byte;
    res            = '0;

    if (go && err_r == ST_OK) begin
      if (phase_r == PH_SKIP) begin
        skip_nxt = skip_r - 64'd1;
        if (skip_r == 64'd1) begin
          phase_nxt = PH_KEY;
        end
      end else if (cnt_r == 4'd9 && item.message_byte[7:1] != 7'd0) begin
        // The tenth byte may only carry the top bit of the value.
        err_nxt = ST_BAD_VARINT;
      end else if (item.message_byte[7]) begin
        acc_nxt = acc_sum;
        cnt_nxt = cnt_r + 4'd1;
      end else begin
        acc_nxt = '0;
        cnt_nxt = '0;
        case (phase_r)
          PH_KEY: begin
            if (acc_sum[63:3] == 61'd0) begin
              err_nxt = ST_FIELD_ZERO;
            end else begin
              case (acc_sum[2:0])
                WT_VARINT: begin
                  match_nxt[0] = (acc_sum[63:32] == 32'd0) && (acc_sum[31:3] == clock_field);
                  match_nxt[1] = (acc_sum[63:32] == 32'd0) && (acc_sum[31:3] == raw_field);
                  phase_nxt    = PH_VALUE;
                end
                WT_FIXED64: begin
                  skip_nxt  = 64'd8;
                  phase_nxt = PH_SKIP;
                end
                WT_LEN: begin
                  phase_nxt = PH_LEN;
                end
                WT_FIXED32: begin
                  skip_nxt  = 64'd4;
                  phase_nxt = PH_SKIP;
                end
                default: begin
                  err_nxt = ST_BAD_WIRE;
                end
              endcase
            end
          end
          PH_VALUE: begin
            if (match_r[0]) begin
              clock_nxt      = acc_sum;
              clock_seen_nxt = 1'b1;
            end
            if (match_r[1]) begin
              raw_nxt = (acc_sum != 64'd0);
            end
            match_nxt = '0;
            phase_nxt = PH_KEY;
          end
          PH_LEN: begin
            if (acc_sum == 64'd0) begin
              phase_nxt = PH_KEY;
            end else begin
              skip_nxt  = acc_sum;
              phase_nxt = PH_SKIP;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (go && item.last_byte) begin
      if (err_nxt != ST_OK) begin
        verdict = err_nxt;
      end else if (phase_nxt == PH_VALUE || phase_nxt == PH_LEN ||
                   (phase_nxt == PH_KEY && cnt_nxt != 4'd0)) begin
        verdict = ST_BAD_VARINT;
      end else if (phase_nxt == PH_SKIP && skip_nxt != 64'd0) begin
        verdict = ST_SKIP_OVERRUN;
      end else if (!clock_seen_nxt) begin
        verdict = ST_MISSING;
      end else if (clock_nxt[63]) begin
        verdict = ST_TOO_LARGE;
      end else begin
        verdict = ST_OK;
      end
      res.status    = verdict;
      res.clock_ms  = (verdict == ST_OK) ? clock_nxt[CLOCK_W-1:0] : '0;
      res.raw_clock = (verdict == ST_OK) && raw_nxt;

      // The message is finished: start the next one from a clean slate.
      phase_nxt      = PH_KEY;
      acc_nxt        = '0;
      cnt_nxt        = '0;
      match_nxt      = '0;
      skip_nxt       = '0;
      clock_nxt      = '0;
      clock_seen_nxt = 1'b0;
      raw_nxt        = 1'b0;
      err_nxt        = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_KEY;
      acc_r        <= '0;
      cnt_r        <= '0;
      match_r      <= '0;
      skip_r       <= '0;
      clock_r      <= '0;
      clock_seen_r <= 1'b0;
      raw_r        <= 1'b0;
      err_r        <= ST_OK;
    end else begin
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      match_r      <= match_nxt;
      skip_r       <= skip_nxt;
      clock_r      <= clock_nxt;
      clock_seen_r <= clock_seen_nxt;
      raw_r        <= raw_nxt;
      err_r        <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    go && item.last_byte |=> phase_r == PH_KEY && cnt_r == 4'd0 && err_r == ST_OK &&
                            !clock_seen_r && skip_r == 64'd0)
    else $error("parser state not cleared after the final byte");

  a_no_count_in_skip: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 4'd0 |-> phase_r != PH_SKIP && cnt_r <= 4'd9)
    else $error("varint byte count live during a skip");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP && err_r == ST_OK |-> skip_r != 64'd0)
    else $error("skip phase with nothing left to skip");

  a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ST_OK && !(go && item.last_byte) |=>
      err_r == $past(err_r) && $stable(clock_r) && $stable(raw_r))
    else $error("state moved after an error inside a message");
`endif

endmodule

/* sv/pfs_result_reg.sv */
`timescale 1ns / 1ps
// Output register of the scanner: holds one result until the consumer takes
// it, and reports whether a new result can be written. Depends on pfs_pkg.
module pfs_result_reg
  import pfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  pfs_result_t load_data,
  input  logic        out_stall,
  output logic        free,
  output logic        out_valid,
  output pfs_result_t out_data
);

  logic        valid_r, valid_nxt;
  pfs_result_t data_r;

  // The slot can take a new result when empty or being emptied this cycle.
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* sv/protobuf_clock_field_scanner_unit.sv */
`timescale 1ns / 1ps
// Top level of the protobuf clock field scanner: input register, field number
// registers, byte parser and output register. Depends on pfs_pkg,
// pfs_byte_parser and pfs_result_reg.
//
//   Channel  Direction  Handshake              Payload
//   in_      sink       in_valid / in_stall    in_message_byte, in_last_byte
//   out_     source     out_valid / out_stall  out_status, out_clock_ms, out_raw_clock
//   cfg_     sink       cfg_wr_en              cfg_index, cfg_data
//
// One byte is taken per clock cycle when nothing stalls. A byte waits in the
// input register until it is parsed, and the result of a final byte is then
// loaded into the output register, from which it can be taken.
// Reset (rst_n low at a clock edge) empties both registers, clears the parse
// state and sets the field numbers to 24 (clock) and 62 (raw flag).
// Only the final byte of a message needs the output register; while a result
// is held under out_stall, non-final bytes keep flowing and a final byte
// waits in the input register, which then stalls the input side.
module protobuf_clock_field_scanner_unit
  import pfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_message_byte,
  input  logic               in_last_byte,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [CLOCK_W-1:0] out_clock_ms,
  output logic               out_raw_clock,

  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [FIELD_W-1:0] cfg_data
);

  // Field numbers that select the clock value and the raw-mode flag.
  logic [FIELD_W-1:0] clock_field_r;
  logic [FIELD_W-1:0] raw_field_r;

  // Input register: one byte waiting to be parsed.
  logic       item_valid_r, item_valid_nxt;
  pfs_item_t  item_r;

  logic        go;
  logic        take;
  logic        out_free;
  logic        res_valid;
  pfs_result_t res;
  pfs_result_t out_data;

  // A byte is parsed when present; a final byte also needs room for its result.
  assign go       = item_valid_r && (!item_r.last_byte || out_free);
  assign in_stall = item_valid_r && !go;
  assign take     = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (take) begin
      item_valid_nxt = 1'b1;
    end else if (go) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r  <= 1'b0;
      clock_field_r <= FIELD_W'(24);
      raw_field_r   <= FIELD_W'(62);
    end else begin
      item_valid_r <= item_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CLOCK_FIELD: clock_field_r <= cfg_data;
          CFG_RAW_FIELD:   raw_field_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.message_byte <= in_message_byte;
      item_r.last_byte    <= in_last_byte;
    end
  end

  pfs_byte_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .item        (item_r),
    .clock_field (clock_field_r),
    .raw_field   (raw_field_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  pfs_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_status    = out_data.status;
  assign out_clock_ms  = out_data.clock_ms;
  assign out_raw_clock = out_data.raw_clock;

endmodule

/* sim/protobuf_clock_field_scanner_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for protobuf_clock_field_scanner_unit: message bytes go in,
// one status/clock/raw-flag summary per message comes out and is checked against a
// local predictor. Depends on pfs_pkg and the scanner RTL only.
module protobuf_clock_field_scanner_unit_tb;
  import pfs_pkg::*;

  // Field numbers that the scanner holds after reset, and the largest one a register holds.
  localparam logic [FIELD_W-1:0] RESET_CLOCK_FIELD = 29'd24;
  localparam logic [FIELD_W-1:0] RESET_RAW_FIELD   = 29'd62;
  localparam logic [FIELD_W-1:0] FIELD_MAX         = 29'h1FFF_FFFF;

  // Wire types that the scanner does not support (groups and the two reserved codes).
  localparam logic [2:0] WT_START_GROUP = 3'd3;
  localparam logic [2:0] WT_END_GROUP   = 3'd4;
  localparam logic [2:0] WT_RESERVED_6  = 3'd6;
  localparam logic [2:0] WT_RESERVED_7  = 3'd7;

  // Where the predictor is within the current field.
  typedef enum logic [1:0] {SEEK_KEY, READ_VALUE, READ_LENGTH, SKIPPING} scan_phase_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_message_byte = 8'h00;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic [CLOCK_W-1:0] out_clock_ms;
  logic               out_raw_clock;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_index = CFG_CLOCK_FIELD;
  logic [FIELD_W-1:0] cfg_data = '0;

  protobuf_clock_field_scanner_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_byte (in_message_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_clock_ms    (out_clock_ms),
    .out_raw_clock   (out_raw_clock),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Message bytes waiting to be driven, and the summaries the scanner owes us, oldest first.
  pfs_item_t   byte_feed[$];
  pfs_result_t expected_summaries[$];
  logic [7:0]  msg_bytes[$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Predictor state: our own copy of the field number registers and of the per-message
  // parse state.
  logic [FIELD_W-1:0] clock_field;
  logic [FIELD_W-1:0] raw_field;
  scan_phase_t        scan_phase;
  logic [63:0]        partial_value;
  int unsigned        partial_bytes;
  logic [1:0]         value_targets;  // bit 0: clock field, bit 1: raw field
  logic [63:0]        skip_left;
  logic [63:0]        last_clock;
  logic               clock_found;
  logic               raw_nonzero;
  status_t            held_error;

  function automatic void clear_scan();
    scan_phase    = SEEK_KEY;
    partial_value = '0;
    partial_bytes = 0;
    value_targets = '0;
    skip_left     = '0;
    last_clock    = '0;
    clock_found   = 1'b0;
    raw_nonzero   = 1'b0;
    held_error    = ST_OK;
  endfunction

  // Advances the predictor by one message byte. On the final byte it returns 1 with the
  // summary that the scanner must give, and the message state starts afresh.
  function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                   output pfs_result_t summary);
    logic [63:0] v;
    logic [63:0] fnum;
    status_t     st;
    summary = '0;
    // Once an error is held, the rest of the message is ignored up to its final byte.
    if (held_error == ST_OK) begin
      if (scan_phase == SKIPPING) begin
        skip_left = skip_left - 64'd1;
        if (skip_left == 64'd0) scan_phase = SEEK_KEY;
      end else if (partial_bytes == 9 && b > 8'd1) begin
        // The tenth varint byte may only carry the top bit of a 64-bit value.
        held_error = ST_BAD_VARINT;
      end else begin
        partial_value = partial_value | (64'(b[6:0]) << (7 * partial_bytes));
        partial_bytes++;
        if (b[7]) begin
          if (partial_bytes >= 10) held_error = ST_BAD_VARINT;
        end else begin
          v = partial_value;
          partial_value = '0;
          partial_bytes = 0;
          case (scan_phase)
            SEEK_KEY: begin
              if (v < 64'd8) begin
                held_error = ST_FIELD_ZERO;
              end else begin
                fnum = v >> 3;
                case (v[2:0])
                  WT_VARINT: begin
                    value_targets = {fnum == 64'(raw_field), fnum == 64'(clock_field)};
                    scan_phase = READ_VALUE;
                  end
                  WT_FIXED64: begin
                    skip_left = 64'd8;
                    scan_phase = SKIPPING;
                  end
                  WT_LEN: scan_phase = READ_LENGTH;
                  WT_FIXED32: begin
                    skip_left = 64'd4;
                    scan_phase = SKIPPING;
                  end
                  default: held_error = ST_BAD_WIRE;
                endcase
              end
            end
            READ_VALUE: begin
              if (value_targets[0]) begin
                last_clock = v;
                clock_found = 1'b1;
              end
              if (value_targets[1]) raw_nonzero = (v != 64'd0);
              value_targets = '0;
              scan_phase = SEEK_KEY;
            end
            default: begin
              // A length of zero means an empty payload, so the next byte is a key.
              if (v == 64'd0) begin
                scan_phase = SEEK_KEY;
              end else begin
                skip_left = v;
                scan_phase = SKIPPING;
              end
            end
          endcase
        end
      end
    end
    if (!last) return 1'b0;

    st = held_error;
    if (st == ST_OK) begin
      if (scan_phase == READ_VALUE || scan_phase == READ_LENGTH ||
          (scan_phase == SEEK_KEY && partial_bytes != 0))
        st = ST_BAD_VARINT;
      else if (scan_phase == SKIPPING && skip_left != 64'd0)
        st = ST_SKIP_OVERRUN;
      else if (!clock_found)
        st = ST_MISSING;
      else if (last_clock[63])
        st = ST_TOO_LARGE;
    end
    summary.status    = st;
    summary.clock_ms  = (st == ST_OK) ? last_clock[CLOCK_W-1:0] : '0;
    summary.raw_clock = (st == ST_OK) && raw_nonzero;
    clear_scan();
    return 1'b1;
  endfunction

  // Sender side. A byte stays on the port until it is taken; a new one is only put up
  // once the previous transfer has happened, or the port was idle.
  always @(posedge clk) begin : byte_driver
    pfs_result_t summary;
    pfs_item_t   item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      clear_scan();
    end else begin
      if (in_valid && !in_stall) begin
        // Queue the expectation before counting the transfer, so that the phase
        // sequencer never sees the count without its summary.
        if (scan_byte(in_message_byte, in_last_byte, summary))
          expected_summaries.insert(expected_summaries.size(), summary);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item = byte_feed.pop_front();
          in_valid        <= 1'b1;
          in_message_byte <= item.message_byte;
          in_last_byte    <= item.last_byte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver side: random stall, and every summary transfer checked field by field
  // against the oldest expectation.
  always @(posedge clk) begin : summary_monitor
    pfs_result_t want;
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_summaries.size() == 0) begin
        $display("%0t: unexpected summary: status %0d clock_ms %0d raw_clock %0b",
                 $time, out_status, out_clock_ms, out_raw_clock);
        mismatch_count++;
      end else begin
        want = expected_summaries.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_clock_ms !== want.clock_ms) begin
          $display("%0t: clock_ms expected %0d actual %0d", $time, want.clock_ms,
                   out_clock_ms);
          mismatch_count++;
        end
        if (out_raw_clock !== want.raw_clock) begin
          $display("%0t: raw_clock expected %0b actual %0b", $time, want.raw_clock,
                   out_raw_clock);
          mismatch_count++;
        end
      end
    end
  end

  // Appends a varint, optionally padded with redundant continuation groups (still at
  // most ten bytes), which the scanner must accept as the same value.
  task automatic add_varint(input logic [63:0] v, input int unsigned pad);
    int unsigned groups;
    int unsigned total;
    logic [63:0] rest;
    groups = 1;
    rest = v >> 7;
    while (rest != 64'd0) begin
      groups++;
      rest = rest >> 7;
    end
    total = groups + pad;
    if (total > 10) total = 10;
    for (int unsigned i = 0; i < total; i++)
      msg_bytes.insert(msg_bytes.size(), {i + 1 < total, 7'(v >> (7 * i))});
  endtask

  function automatic int unsigned pad_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  task automatic add_key(input logic [60:0] fnum, input logic [2:0] wire_type);
    add_varint({fnum, wire_type}, pad_len());
  endtask

  task automatic add_random_bytes(input int unsigned n);
    repeat (n) msg_bytes.insert(msg_bytes.size(), 8'($urandom));
  endtask

  // A field number for the other fields: sometimes one of the configured numbers (which
  // matches when the wire type is a varint), sometimes one that agrees with the clock
  // field in its low 29 bits but is wider, and so must never match.
  function automatic logic [60:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 61'(clock_field);
      1: return 61'(raw_field);
      2: return 61'(clock_field) | (61'($urandom_range(1, 255)) << FIELD_W);
      3: return 61'({$urandom, $urandom} >> 3) | 61'd1;
      default: return 61'($urandom_range(1, 1000));
    endcase
  endfunction

  // Moves the assembled message into the feed, marking its final byte.
  task automatic queue_message();
    pfs_item_t entry;
    for (int i = 0; i < msg_bytes.size(); i++) begin
      entry.message_byte = msg_bytes[i];
      entry.last_byte    = (i == msg_bytes.size() - 1);
      byte_feed.insert(byte_feed.size(), entry);
      bytes_queued++;
    end
    msg_bytes.delete();
  endtask

  // Builds one message. Most are well formed with random content; some carry broken
  // fields (bad wire type, field number zero, overlong varint, length past the end), some
  // are also cut short, and a few are plain noise.
  task automatic add_random_message();
    int unsigned style;
    int unsigned nfields;
    int unsigned n;
    logic [63:0] v;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      add_random_bytes($urandom_range(1, 12));
    end else begin
      nfields = $urandom_range(1, 5);
      repeat (nfields) begin
        case ((style >= 8) ? $urandom_range(0, 12) : $urandom_range(0, 8))
          0, 1, 8: begin
            // Clock values lean towards the extremes and past the signed 64-bit limit.
            case ($urandom_range(0, 7))
              0: v = 64'd0;
              1: v = 64'h7FFF_FFFF_FFFF_FFFF;
              2: v = 64'h8000_0000_0000_0000;
              3: v = '1;
              4, 5: v = 64'($urandom_range(0, 100000));
              default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            endcase
            add_key(61'(clock_field), WT_VARINT);
            add_varint(v, pad_len());
          end
          2: begin
            add_key(61'(raw_field), WT_VARINT);
            add_varint($urandom_range(0, 1) ? 64'd0 : {$urandom, $urandom} >>
                       $urandom_range(0, 63), pad_len());
          end
          3: begin
            add_key(pick_field(), WT_VARINT);
            add_varint({$urandom, $urandom} >> $urandom_range(0, 63), pad_len());
          end
          4: begin
            add_key(pick_field(), WT_FIXED64);
            add_random_bytes(8);
          end
          5: begin
            add_key(pick_field(), WT_FIXED32);
            add_random_bytes(4);
          end
          6, 7: begin
            n = $urandom_range(0, 10);
            add_key(pick_field(), WT_LEN);
            add_varint(64'(n), pad_len());
            add_random_bytes(n);
          end
          9: begin
            case ($urandom_range(0, 3))
              0: add_key(pick_field(), WT_START_GROUP);
              1: add_key(pick_field(), WT_END_GROUP);
              2: add_key(pick_field(), WT_RESERVED_6);
              default: add_key(pick_field(), WT_RESERVED_7);
            endcase
          end
          10: add_varint(64'($urandom_range(0, 7)), pad_len());
          11: begin
            // Nine continuation bytes, then a tenth that does not fit in 64 bits.
            repeat (9)
              msg_bytes.insert(msg_bytes.size(), 8'h80 | 8'($urandom_range(0, 127)));
            msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(2, 255)));
          end
          default: begin
            // A length far beyond what the message still holds.
            add_key(pick_field(), WT_LEN);
            add_varint($urandom_range(0, 1) ? 64'($urandom_range(20, 1000)) : '1, 0);
          end
        endcase
      end
      if (style == 9 && msg_bytes.size() > 1)
        repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
    end
    queue_message();
  endtask

  task automatic fill_phase(input int unsigned budget);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < budget) add_random_message();
  endtask

  // Waits until every byte has been taken and every summary has come back, then lets
  // the scanner's input and output registers run empty with some margin.
  task automatic drain();
    while (bytes_taken != bytes_queued || expected_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Field number writes are only made while the scanner is idle.
  task automatic write_reg(input logic idx, input logic [FIELD_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_CLOCK_FIELD) clock_field = val;
    else raw_field = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [FIELD_W-1:0] FIELD_FIELD_RANDOM();
    return ($urandom_range(0, 1) == 0) ? FIELD_W'($urandom_range(1, 100))
                                       : FIELD_W'($urandom_range(1, FIELD_MAX));
  endfunction

  initial begin : sequencer
    logic [FIELD_W-1:0] shared_field;
    clock_field = RESET_CLOCK_FIELD;
    raw_field   = RESET_RAW_FIELD;
    send_idle_pct = 7;
    recv_idle_pct = 45;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed messages with the reset field numbers (clock 24, raw 62).
    // Clock of zero followed by a nonzero raw flag: good status, raw set.
    msg_bytes = '{8'hC0, 8'h01, 8'h00, 8'hF0, 8'h03, 8'h01};
    queue_message();
    // A key below eight means field number zero.
    msg_bytes = '{8'h07};
    queue_message();
    // Field 1 with a group wire type, which is not supported.
    msg_bytes = '{8'h0B};
    queue_message();
    // The message ends inside a key varint.
    msg_bytes = '{8'h80};
    queue_message();
    // Length-delimited field announcing five bytes but only one follows.
    msg_bytes = '{8'h0A, 8'h05, 8'h00};
    queue_message();
    // An empty length-delimited field and nothing else: the clock is missing.
    msg_bytes = '{8'h0A, 8'h00};
    queue_message();
    // A key whose tenth byte is too big.
    repeat (9) msg_bytes.insert(msg_bytes.size(), 8'h80);
    msg_bytes.insert(msg_bytes.size(), 8'h02);
    queue_message();
    drain();

    // Smallest clock field number, largest raw field number.
    write_reg(CFG_CLOCK_FIELD, 29'd1);
    write_reg(CFG_RAW_FIELD, FIELD_MAX);
    fill_phase(480);
    drain();

    // The receiver now stalls rarely and the sender idles often.
    send_idle_pct = 45;
    recv_idle_pct = 7;
    // Both registers on the same field: one varint updates clock and raw flag together.
    shared_field = FIELD_FIELD_RANDOM();
    write_reg(CFG_CLOCK_FIELD, shared_field);
    write_reg(CFG_RAW_FIELD, shared_field);
    fill_phase(480);
    drain();

    // Largest clock field number, smallest raw field number.
    write_reg(CFG_CLOCK_FIELD, FIELD_MAX);
    write_reg(CFG_RAW_FIELD, 29'd1);
    fill_phase(480);
    drain();

    // Full rate on both sides with random field numbers.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_CLOCK_FIELD, FIELD_FIELD_RANDOM());
    write_reg(CFG_RAW_FIELD, FIELD_FIELD_RANDOM());
    fill_phase(480);
    drain();

    if (mismatch_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Generous bound, far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
